[src/cube_to_sphere_map_macros.svh]
// Assertion macros for the cube to sphere mapper
`ifndef CUBE_TO_SPHERE_MAP_MACROS_SVH
`define CUBE_TO_SPHERE_MAP_MACROS_SVH

// same-cycle implication
`define C2S_AST_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// implication after a fixed number of cycles
`define C2S_AST_DLY(lbl, pre, n, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> ##n (post)) \
    else $error(msg);

`endif

[src/c2s_pkg.sv]
`default_nettype none

package c2s_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int COORD_W       = 16;
  localparam int SQ_W          = 31;  // square of a 16-bit magnitude
  localparam int QUAD_W        = 61;  // (|a||b|)^2
  localparam int SUM_W         = 62;
  localparam int NEG_W         = 33;  // 2a^2 + 2b^2
  localparam int DIV_LAT       = 3;   // registers in the divide-by-3 pipe

  localparam logic [COORD_W-1:0] SAT_POS = 16'h7FFF;
  localparam logic [COORD_W-1:0] SAT_NEG = 16'h8000;

  // width of (t + d/2) >> (2F-2), also the quotient width
  function automatic int quot_w(input int frac);
    return 64 - 2 * frac;
  endfunction

  // radicand width
  function automatic int rad_w(input int frac);
    int a;
    int b;
    a = 2 * frac + 3;
    b = quot_w(frac);
    return ((a > b) ? a : b) + 1;
  endfunction

  function automatic int root_w(input int frac);
    return (rad_w(frac) + 1) / 2;
  endfunction

  // registers from lane input to lane result
  function automatic int lane_lat(input int frac);
    return 6 + DIV_LAT + root_w(frac);
  endfunction

endpackage

`default_nettype wire

[src/c2s_div3.sv]
`default_nettype none

module c2s_div3 import c2s_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  wire logic                             clk_i,
  input  wire logic [quot_w(FRAC_BITS)-1:0]     num_i,
  input  wire logic [SIDE_W-1:0]                side_i,
  output logic      [quot_w(FRAC_BITS)-1:0]     quo_o,
  output logic      [SIDE_W-1:0]                side_o
);

  localparam int QW = quot_w(FRAC_BITS);  // always even
  localparam int HW = QW / 2;
  localparam int SH = QW + 1;
  localparam int PW = 2 * QW;

  // (2^SH + 1) / 3, exact since SH is odd; floor(n * RECIP / 2^SH) = floor(n / 3)
  // for every n below 2^SH
  localparam logic [QW-1:0] RECIP = QW'(((64'd1 << SH) + 64'd1) / 64'd3);
  localparam logic [HW-1:0] RC_LO = RECIP[HW-1:0];
  localparam logic [HW-1:0] RC_HI = RECIP[QW-1:HW];

  logic [HW-1:0]     n_lo, n_hi;
  logic [QW-1:0]     ll_q, lh_q, hl_q, hh_q;
  logic [QW:0]       mid_q;
  logic [PW-1:0]     cat_q;
  logic [PW-1:0]     prod;
  logic [QW-1:0]     quo_q;
  logic [SIDE_W-1:0] side_a_q, side_b_q, side_c_q;

  assign n_lo = num_i[HW-1:0];
  assign n_hi = num_i[QW-1:HW];

  // half-width partial products
  always_ff @(posedge clk_i) begin
    ll_q     <= n_lo * RC_LO;
    lh_q     <= n_lo * RC_HI;
    hl_q     <= n_hi * RC_LO;
    hh_q     <= n_hi * RC_HI;
    side_a_q <= side_i;
  end

  always_ff @(posedge clk_i) begin
    mid_q    <= (QW + 1)'(lh_q) + (QW + 1)'(hl_q);
    cat_q    <= {hh_q, ll_q};
    side_b_q <= side_a_q;
  end

  assign prod = cat_q + (PW'(mid_q) << HW);

  always_ff @(posedge clk_i) begin
    quo_q    <= QW'(prod[PW-1:SH]);
    side_c_q <= side_b_q;
  end

  assign quo_o  = quo_q;
  assign side_o = side_c_q;

endmodule

`default_nettype wire

[src/c2s_isqrt.sv]
`default_nettype none

module c2s_isqrt import c2s_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  wire logic                            clk_i,
  input  wire logic [rad_w(FRAC_BITS)-1:0]     rad_i,
  input  wire logic [SIDE_W-1:0]               side_i,
  output logic      [root_w(FRAC_BITS)-1:0]    root_o,
  output logic      [SIDE_W-1:0]               side_o
);

  localparam int SW = root_w(FRAC_BITS);
  localparam int XW = 2 * SW;
  localparam int MW = SW + 2;

  logic [XW-1:0]     rad_q  [SW];
  logic [SW-1:0]     root_q [SW];
  logic [MW-1:0]     rem_q  [SW];
  logic [SIDE_W-1:0] side_q [SW];

  for (genvar k = 0; k < SW; k++) begin : g_bit
    logic [XW-1:0]     rad_in;
    logic [SW-1:0]     root_in;
    logic [MW-1:0]     rem_in;
    logic [SIDE_W-1:0] side_in;
    logic [MW-1:0]     cur;
    logic [MW-1:0]     trial;
    logic [SW-1:0]     root_d;
    logic [MW-1:0]     rem_d;

    if (k == 0) begin : g_first
      assign rad_in  = XW'(rad_i);
      assign root_in = '0;
      assign rem_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign root_in = root_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign cur   = {rem_in[MW-3:0], rad_in[XW-1-2*k -: 2]};
    assign trial = {root_in, 2'b01};

    always_comb begin
      if (cur >= trial) begin
        rem_d  = cur - trial;
        root_d = {root_in[SW-2:0], 1'b1};
      end else begin
        rem_d  = cur;
        root_d = {root_in[SW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= rad_in;
      root_q[k] <= root_d;
      rem_q[k]  <= rem_d;
      side_q[k] <= side_in;
    end
  end

  assign root_o = root_q[SW-1];
  assign side_o = side_q[SW-1];

endmodule

`default_nettype wire

[src/c2s_lane.sv]
`default_nettype none

module c2s_lane import c2s_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic signed [COORD_W-1:0]  a_i,
  input  wire logic signed [COORD_W-1:0]  b_i,
  input  wire logic signed [COORD_W-1:0]  c_i,
  output logic signed      [COORD_W-1:0]  res_o
);

  localparam int QW     = quot_w(FRAC_BITS);
  localparam int PW     = rad_w(FRAC_BITS);
  localparam int SW     = root_w(FRAC_BITS);
  localparam int MW     = COORD_W + SW;
  localparam int VW     = MW - FRAC_BITS;
  localparam int SIDE_W = NEG_W + COORD_W;

  localparam logic [SUM_W-1:0] HALF_D  = SUM_W'(3) << (2 * FRAC_BITS - 3);
  localparam logic [PW-1:0]    ONE_R   = PW'(1) << (2 * FRAC_BITS + 2);
  localparam logic [MW:0]      RND_H   = (MW + 1)'(1) << FRAC_BITS;

  // stage 1: squares and cross product
  logic [COORD_W-1:0]        ma, mb;
  logic [2*COORD_W-1:0]      aa_full, bb_full, p_full;
  logic [SQ_W-1:0]           aa_q, bb_q, p_q;
  logic signed [COORD_W-1:0] c1_q;

  assign ma      = a_i[COORD_W-1] ? COORD_W'(-a_i) : a_i;
  assign mb      = b_i[COORD_W-1] ? COORD_W'(-b_i) : b_i;
  assign aa_full = ma * ma;
  assign bb_full = mb * mb;
  assign p_full  = ma * mb;

  always_ff @(posedge clk_i) begin
    aa_q <= aa_full[SQ_W-1:0];
    bb_q <= bb_full[SQ_W-1:0];
    p_q  <= p_full[SQ_W-1:0];
    c1_q <= c_i;
  end

  // stage 2: a^2 b^2 and 2a^2 + 2b^2
  logic [2*SQ_W-1:0]         t_full;
  logic [QUAD_W-1:0]         t_q;
  logic [NEG_W-1:0]          neg_q;
  logic signed [COORD_W-1:0] c2_q;

  assign t_full = p_q * p_q;

  always_ff @(posedge clk_i) begin
    t_q   <= t_full[QUAD_W-1:0];
    neg_q <= {1'b0, aa_q, 1'b0} + {1'b0, bb_q, 1'b0};
    c2_q  <= c1_q;
  end

  // rounded a^2 b^2 / (3 * 2^(2F-2))
  logic [SUM_W-1:0]  sum;
  logic [QW-1:0]     quo;
  logic [SIDE_W-1:0] dv_side;

  assign sum = SUM_W'(t_q) + HALF_D;

  c2s_div3 #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (SIDE_W)
  ) u_div3 (
    .clk_i  (clk_i),
    .num_i  (sum[SUM_W-1:2*FRAC_BITS-2]),
    .side_i ({neg_q, c2_q}),
    .quo_o  (quo),
    .side_o (dv_side)
  );

  // radicand, negative clamps to zero
  logic [PW-1:0]             pos_q;
  logic [NEG_W-1:0]          neg3_q;
  logic signed [COORD_W-1:0] c3_q;
  logic [PW-1:0]             rad_q;
  logic signed [COORD_W-1:0] c4_q;

  always_ff @(posedge clk_i) begin
    pos_q  <= ONE_R + PW'(quo);
    neg3_q <= dv_side[SIDE_W-1:COORD_W];
    c3_q   <= dv_side[COORD_W-1:0];
    rad_q  <= (pos_q > PW'(neg3_q)) ? pos_q - PW'(neg3_q) : '0;
    c4_q   <= c3_q;
  end

  logic [SW-1:0]             root;
  logic signed [COORD_W-1:0] c5;

  c2s_isqrt #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (COORD_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rad_i  (rad_q),
    .side_i (c4_q),
    .root_o (root),
    .side_o (c5)
  );

  // scale, round half away from zero, saturate
  logic [COORD_W-1:0]        mc;
  logic [MW-1:0]             m_q;
  logic                      sgn_q;
  logic [MW:0]               rnd;
  logic [VW-1:0]             qv;
  logic signed [COORD_W-1:0] res_d, res_q;

  assign mc = c5[COORD_W-1] ? COORD_W'(-c5) : c5;

  always_ff @(posedge clk_i) begin
    m_q   <= mc * root;
    sgn_q <= c5[COORD_W-1];
  end

  assign rnd = (MW + 1)'(m_q) + RND_H;
  assign qv  = rnd[MW:FRAC_BITS+1];

  always_comb begin
    if (sgn_q) begin
      res_d = (qv > VW'(SAT_NEG)) ? SAT_NEG : COORD_W'(-qv);
    end else begin
      res_d = (qv > VW'(SAT_POS)) ? SAT_POS : qv[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[src/cube_to_sphere_map.sv]
// Channel  | Direction | Handshake          | Word
// ---------+-----------+--------------------+---------------------------------
// command  | in        | start / busy       | cube_x_i, cube_y_i, cube_z_i
// result   | out       | done_o (one cycle) | sphere_x_o, sphere_y_o, sphere_z_o
//
// One word per cycle; busy stays low, every start is taken.
// The result path runs through the divide-by-3 multiply and bit-per-stage square root pipes
// of each lane, then the output register.
// Three lanes run in parallel, one per output coordinate.
// Reset clears only the valid pipe; payload stages are free running.
// Results are held in the output registers until the next word; done_o marks each word valid for one cycle.

`default_nettype none

`include "cube_to_sphere_map_macros.svh"

module cube_to_sphere_map import c2s_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic signed [COORD_W-1:0]  cube_x_i,
  input  wire logic signed [COORD_W-1:0]  cube_y_i,
  input  wire logic signed [COORD_W-1:0]  cube_z_i,
  output logic                            done_o,
  output logic signed      [COORD_W-1:0]  sphere_x_o,
  output logic signed      [COORD_W-1:0]  sphere_y_o,
  output logic signed      [COORD_W-1:0]  sphere_z_o
);

  localparam int LAT     = lane_lat(FRAC_BITS);
  localparam int TOT_LAT = LAT + 1;

  logic                      accept;
  logic [LAT-1:0]            vld_q;
  logic                      done_q;
  logic signed [COORD_W-1:0] lane_x, lane_y, lane_z;
  logic signed [COORD_W-1:0] sx_q, sy_q, sz_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  c2s_lane #(.FRAC_BITS (FRAC_BITS)) u_lane_x (
    .clk_i (clk_i),
    .a_i   (cube_y_i),
    .b_i   (cube_z_i),
    .c_i   (cube_x_i),
    .res_o (lane_x)
  );

  c2s_lane #(.FRAC_BITS (FRAC_BITS)) u_lane_y (
    .clk_i (clk_i),
    .a_i   (cube_x_i),
    .b_i   (cube_z_i),
    .c_i   (cube_y_i),
    .res_o (lane_y)
  );

  c2s_lane #(.FRAC_BITS (FRAC_BITS)) u_lane_z (
    .clk_i (clk_i),
    .a_i   (cube_x_i),
    .b_i   (cube_y_i),
    .c_i   (cube_z_i),
    .res_o (lane_z)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[LAT-2:0], accept};
      done_q <= vld_q[LAT-1];
    end
  end

  // merge the three lanes into the result word
  always_ff @(posedge clk_i) begin
    if (vld_q[LAT-1]) begin
      sx_q <= lane_x;
      sy_q <= lane_y;
      sz_q <= lane_z;
    end
  end

  assign done_o     = done_q;
  assign sphere_x_o = sx_q;
  assign sphere_y_o = sy_q;
  assign sphere_z_o = sz_q;

  `C2S_AST_DLY(a_done_follows, accept, TOT_LAT, done_o, "accepted word produced no result")
  `C2S_AST_IMP(a_done_caused, done_o, $past(accept, TOT_LAT), "result without a command")
  `C2S_AST_DLY(a_zero_x, accept && (cube_x_i == '0), TOT_LAT, sphere_x_o == '0, "x not zero")
  `C2S_AST_DLY(a_sign_z, accept && !cube_z_i[COORD_W-1], TOT_LAT, !sphere_z_o[COORD_W-1], "z sign flipped")

endmodule

`default_nettype wire
